/* rtl/core/framed_message_receiver_crc8_defines.svh */
// Assertion macros shared by the receiver RTL.
`ifndef FRAMED_MESSAGE_RECEIVER_CRC8_DEFINES_SVH
`define FRAMED_MESSAGE_RECEIVER_CRC8_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, checked out of reset
`define FMR_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");

// Next-cycle implication, checked out of reset
`define FMR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`else

`define FMR_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define FMR_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

/* rtl/core/fmrcrc8_pkg.sv */
// Constants, status codes and CRC-8 helper for the framed message receiver.
package fmrcrc8_pkg;

    // Message buffer depth; body and header counts stop one short of it
    localparam int BUFFER_LEN = 64;
    localparam int CNT_W      = $clog2(BUFFER_LEN);

    // Port field widths
    localparam int BYTE_W   = 8;
    localparam int STATUS_W = 3;
    localparam int LEN_W    = 6;
    localparam int CFG_IDX_W = 2;

    // Receiver status codes
    localparam logic [STATUS_W-1:0] ST_IDLE = 3'd0;
    localparam logic [STATUS_W-1:0] ST_HDR  = 3'd1;
    localparam logic [STATUS_W-1:0] ST_ACT  = 3'd2;
    localparam logic [STATUS_W-1:0] ST_RDY  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_ABT  = 3'd4;
    localparam logic [STATUS_W-1:0] ST_BOF  = 3'd5;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_START      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEADER_END = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_END        = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MASTER     = 2'd3;

    // Configuration reset values
    localparam logic [BYTE_W-1:0] START_RST      = 8'hF0;
    localparam logic [BYTE_W-1:0] HEADER_END_RST = 8'hF1;
    localparam logic [BYTE_W-1:0] END_RST        = 8'hF2;
    localparam logic [BYTE_W-1:0] MASTER_RST     = 8'hFF;

    // Header parsing
    localparam logic [BYTE_W-1:0] RANGE_MARK = 8'h2D;
    localparam logic [CNT_W-1:0]  MAX_HEADER = CNT_W'(5);
    localparam int HDR_DEPTH = 4;

    typedef logic [BYTE_W-1:0] byte_t;

    // One byte of Dallas/Maxim CRC-8, reflected polynomial 0x8C
    function automatic byte_t crc8_step(input byte_t crc, input byte_t data);
        byte_t v;
        v = crc ^ data;
        for (int i = 0; i < 8; i++) begin
            v = v[0] ? ((v >> 1) ^ 8'h8C) : (v >> 1);
        end
        return v;
    endfunction

endpackage

/* rtl/core/framed_message_receiver_crc8.sv */
// Framed message receiver: header parse, body echo and CRC-8 check, one byte per cycle.
// One received byte per transaction, one result per byte. Bytes are taken every cycle
// while the result side keeps up; a byte's result reaches the outputs through the
// input register, then the result register that holds the updated receiver state.
// All of the per-byte work, including the three-byte header CRC seed, is done in the
// single logic stage ahead of the result register. The start, header-end and end byte
// values and the master address must be written through the configuration port only
// while idle; the block itself does not enforce this.
`include "framed_message_receiver_crc8_defines.svh"

module framed_message_receiver_crc8 (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // received byte channel
    input  logic                                 byte_valid,
    output logic                                 byte_stall,
    input  logic [fmrcrc8_pkg::BYTE_W-1:0]       rx_byte,
    // result channel
    output logic                                 result_valid,
    input  logic                                 result_stall,
    output logic [fmrcrc8_pkg::STATUS_W-1:0]     status,
    output logic [fmrcrc8_pkg::BYTE_W-1:0]       body_byte,
    output logic                                 body_byte_valid,
    output logic [fmrcrc8_pkg::LEN_W-1:0]        body_index,
    output logic [fmrcrc8_pkg::BYTE_W-1:0]       dest_low,
    output logic [fmrcrc8_pkg::BYTE_W-1:0]       dest_high,
    output logic [fmrcrc8_pkg::BYTE_W-1:0]       source_address,
    output logic [fmrcrc8_pkg::BYTE_W-1:0]       message_type,
    output logic [fmrcrc8_pkg::LEN_W-1:0]        body_length,
    // configuration write channel
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [fmrcrc8_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [fmrcrc8_pkg::BYTE_W-1:0]       cfg_data
);
    import fmrcrc8_pkg::*;

    // configuration registers
    byte_t start_reg, header_end_reg, end_reg, master_reg;

    // input stage
    logic  s1_valid_reg;
    byte_t s1_byte_reg;

    // receiver state
    logic [STATUS_W-1:0] status_reg, status_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    byte_t               dl_reg, dl_next;
    byte_t               dh_reg, dh_next;
    byte_t               src_reg, src_next;
    byte_t               type_reg, type_next;
    byte_t               crc_reg, crc_next;
    byte_t               pend_reg, pend_next;
    byte_t               hdr_mem [HDR_DEPTH];
    logic                hdr_we;

    // result register
    logic                res_valid_reg;
    logic [STATUS_W-1:0] res_status_reg;
    byte_t               res_byte_reg;
    logic                res_bv_reg;
    logic [LEN_W-1:0]    res_idx_reg;
    byte_t               res_dl_reg, res_dh_reg, res_src_reg, res_type_reg;
    logic [LEN_W-1:0]    res_len_reg;

    // per-byte combinational results
    logic             bv_next;
    logic [CNT_W-1:0] bidx_next;
    logic [CNT_W-1:0] count_inc;
    byte_t            c;
    byte_t            h0, h1, h2, h3;
    byte_t            p_dh, p_src;
    logic             res_load, s1_load;

    // handshake
    assign res_load   = s1_valid_reg && (!res_valid_reg || !result_stall);
    assign byte_stall = s1_valid_reg && !res_load;
    assign s1_load    = byte_valid && !byte_stall;
    assign cfg_ready  = 1'b1;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_reg      <= START_RST;
            header_end_reg <= HEADER_END_RST;
            end_reg        <= END_RST;
            master_reg     <= MASTER_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_START:      start_reg      <= cfg_data;
                CFG_HEADER_END: header_end_reg <= cfg_data;
                CFG_END:        end_reg        <= cfg_data;
                CFG_MASTER:     master_reg     <= cfg_data;
                default:        ;
            endcase
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (s1_load)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (res_load)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_load)
        begin
            s1_byte_reg <= rx_byte;
        end
    end

    // header view: positions 1 to 3 at or past the count read as zero
    assign c  = s1_byte_reg;
    assign h0 = hdr_mem[0];
    assign h1 = (count_reg > CNT_W'(1)) ? hdr_mem[1] : '0;
    assign h2 = (count_reg > CNT_W'(2)) ? hdr_mem[2] : '0;
    assign h3 = (count_reg > CNT_W'(3)) ? hdr_mem[3] : '0;

    always_comb
    begin
        if (h1 == RANGE_MARK)
        begin
            p_dh  = h2;
            p_src = (count_reg > CNT_W'(3)) ? h3 : master_reg;
        end
        else
        begin
            p_dh  = h0;
            p_src = (count_reg > CNT_W'(1)) ? h1 : master_reg;
        end
    end

    assign count_inc = count_reg + CNT_W'(1);

    // per-byte state update
    always_comb
    begin
        status_next = status_reg;
        count_next  = count_reg;
        dl_next     = dl_reg;
        dh_next     = dh_reg;
        src_next    = src_reg;
        type_next   = type_reg;
        crc_next    = crc_reg;
        pend_next   = pend_reg;
        hdr_we      = 1'b0;
        bv_next     = 1'b0;
        bidx_next   = '0;

        if (c == start_reg)
        begin
            status_next = ST_HDR;
            count_next  = '0;
            dl_next     = '0;
            dh_next     = '0;
            src_next    = '0;
            type_next   = '0;
            crc_next    = '0;
            pend_next   = '0;
        end
        else if (status_reg inside {ST_RDY, ST_ABT, ST_BOF})
        begin
            // hold until the next start byte
        end
        else if (c == end_reg)
        begin
            if (status_reg == ST_ACT)
            begin
                if (count_reg == '0)
                begin
                    status_next = ST_ABT;
                end
                else
                begin
                    count_next  = count_reg - CNT_W'(1);
                    status_next = (crc_reg == pend_reg) ? ST_RDY : ST_ABT;
                end
            end
            else
            begin
                status_next = ST_IDLE;
                count_next  = '0;
                dl_next     = '0;
                dh_next     = '0;
                src_next    = '0;
                type_next   = '0;
                crc_next    = '0;
                pend_next   = '0;
            end
        end
        else if (status_reg == ST_HDR)
        begin
            if (c == header_end_reg)
            begin
                count_next = '0;
                if (count_reg == '0 || count_reg > MAX_HEADER)
                begin
                    status_next = ST_ABT;
                end
                else
                begin
                    status_next = ST_ACT;
                    dl_next     = h0;
                    dh_next     = p_dh;
                    src_next    = p_src;
                    crc_next    = crc8_step(crc8_step(crc8_step('0, h0), p_dh), p_src);
                end
            end
            else
            begin
                hdr_we     = (count_reg < CNT_W'(HDR_DEPTH));
                count_next = count_inc;
                if (count_inc == CNT_W'(BUFFER_LEN - 1))
                begin
                    status_next = ST_BOF;
                    count_next  = '0;
                end
            end
        end
        else if (status_reg == ST_ACT)
        begin
            if (type_reg == '0 && count_reg == '0)
            begin
                type_next = c;
            end
            else
            begin
                crc_next   = crc8_step(crc_reg, (count_reg == '0) ? type_reg : pend_reg);
                pend_next  = c;
                bv_next    = 1'b1;
                bidx_next  = count_reg;
                count_next = count_inc;
                if (count_inc == CNT_W'(BUFFER_LEN - 1))
                begin
                    status_next = ST_BOF;
                end
            end
        end
    end

    // receiver state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            status_reg <= ST_IDLE;
            count_reg  <= '0;
            dl_reg     <= '0;
            dh_reg     <= '0;
            src_reg    <= '0;
            type_reg   <= '0;
            crc_reg    <= '0;
            pend_reg   <= '0;
        end
        else if (res_load)
        begin
            status_reg <= status_next;
            count_reg  <= count_next;
            dl_reg     <= dl_next;
            dh_reg     <= dh_next;
            src_reg    <= src_next;
            type_reg   <= type_next;
            crc_reg    <= crc_next;
            pend_reg   <= pend_next;
        end
    end

    // header byte store
    always_ff @(posedge clk)
    begin
        if (res_load && hdr_we)
        begin
            hdr_mem[count_reg[1:0]] <= c;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (res_load)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (!result_stall)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_load)
        begin
            res_status_reg <= status_next;
            res_byte_reg   <= bv_next ? c : '0;
            res_bv_reg     <= bv_next;
            res_idx_reg    <= LEN_W'(bidx_next);
            res_dl_reg     <= dl_next;
            res_dh_reg     <= dh_next;
            res_src_reg    <= src_next;
            res_type_reg   <= type_next;
            res_len_reg    <= (status_next == ST_HDR) ? '0 : LEN_W'(count_next);
        end
    end

    assign result_valid    = res_valid_reg;
    assign status          = res_status_reg;
    assign body_byte       = res_byte_reg;
    assign body_byte_valid = res_bv_reg;
    assign body_index      = res_idx_reg;
    assign dest_low        = res_dl_reg;
    assign dest_high       = res_dh_reg;
    assign source_address  = res_src_reg;
    assign message_type    = res_type_reg;
    assign body_length     = res_len_reg;

    // checks
    `FMR_ASSERT_IMPLY(a_echo_in_body, clk, rst_n, res_valid_reg && res_bv_reg, (res_status_reg == ST_ACT || res_status_reg == ST_BOF))
    `FMR_ASSERT_IMPLY(a_hdr_fields_clear, clk, rst_n, status_reg == ST_HDR, (type_reg == '0 && dl_reg == '0 && crc_reg == '0))
    `FMR_ASSERT_IMPLY(a_stall_only_full, clk, rst_n, byte_stall, s1_valid_reg && res_valid_reg)
    `FMR_ASSERT_NEXT(a_result_follows, clk, rst_n, res_load, res_valid_reg)

endmodule
